// ===== rtl/apphd_pkg.sv =====
// ----------------------------------------------------------------------------
// apphd_pkg: shared types and constants of the arm pose hold detector
// Field widths, register reset values, multiplier operation codes, the
// controller state type and the command and status bundles.
// ----------------------------------------------------------------------------
package apphd_pkg;

  // Payload and register widths
  localparam int unsigned JOINT_W = 48;
  localparam int unsigned LIM_W   = 9;
  localparam int unsigned HOLD_W  = 8;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  // Register reset values
  localparam logic [LIM_W-1:0]  COS_LIMIT_RST   = 9'd77;
  localparam logic [HOLD_W-1:0] HOLD_FRAMES_RST = 8'd5;

  // Register index, taken from paddr bit 2
  localparam logic REG_COS_LIMIT   = 1'b0;
  localparam logic REG_HOLD_FRAMES = 1'b1;

  // Operation issued to the shared multiplier
  typedef enum logic [2:0] {
    OP_LIM2,   // limit squared
    OP_NORM,   // squared length of one vector
    OP_DOT,    // dot product of axis and arm
    OP_QUAD,   // product of the two squared lengths
    OP_LSQ,    // subtract squared dot product, scaled by 2^16
    OP_RLIM    // add length product times limit squared
  } mul_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LIM2,
    ST_NORM,
    ST_DOT,
    ST_QUAD,
    ST_LSQ,
    ST_RLIM,
    ST_DRAIN,
    ST_FINISH
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic      load;
    logic      issue;
    mul_op_e   op;
    logic [1:0] vec;
    logic [1:0] term;
    logic      finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic run;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/apphd_intf.sv =====
// ----------------------------------------------------------------------------
// apphd_intf: frame and result channels
// Valid/ready channels carrying one skeleton frame and one detection result.
// ----------------------------------------------------------------------------
interface apphd_in_if;
  logic                          valid;
  logic                          ready;
  logic                          tracking;
  logic                          joints_valid;
  logic [apphd_pkg::JOINT_W-1:0] left_shoulder;
  logic [apphd_pkg::JOINT_W-1:0] left_hand;
  logic [apphd_pkg::JOINT_W-1:0] right_shoulder;
  logic [apphd_pkg::JOINT_W-1:0] right_hand;
  logic [apphd_pkg::JOINT_W-1:0] neck;
  logic [apphd_pkg::JOINT_W-1:0] head;

  modport source (
    output valid, tracking, joints_valid, left_shoulder, left_hand,
           right_shoulder, right_hand, neck, head,
    input  ready
  );
  modport sink (
    input  valid, tracking, joints_valid, left_shoulder, left_hand,
           right_shoulder, right_hand, neck, head,
    output ready
  );
endinterface

interface apphd_out_if;
  logic valid;
  logic ready;
  logic pose_now;
  logic pose_found;
  logic pose_lost;
  logic posing;

  modport source (
    output valid, pose_now, pose_found, pose_lost, posing,
    input  ready
  );
  modport sink (
    input  valid, pose_now, pose_found, pose_lost, posing,
    output ready
  );
endinterface

// ===== rtl/apphd_ctrl.sv =====
// ----------------------------------------------------------------------------
// apphd_ctrl: sequencer of the pose detector
// Walks one frame through limit squaring, vector lengths, dot products and
// the four perpendicularity tests, one multiplier operation per cycle.
// ----------------------------------------------------------------------------
module apphd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  apphd_pkg::sts_t   sts_i,
  output apphd_pkg::cmd_t   cmd_o
);

  apphd_pkg::ctrl_state_e state_q, state_d;
  logic [1:0] vec_q, vec_d;
  logic [1:0] term_q, term_d;

  // Hold state and step counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= apphd_pkg::ST_IDLE;
      vec_q   <= '0;
      term_q  <= '0;
    end else begin
      state_q <= state_d;
      vec_q   <= vec_d;
      term_q  <= term_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      apphd_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = apphd_pkg::ST_LIM2;
      end
      apphd_pkg::ST_LIM2: begin
        state_d = sts_i.run ? apphd_pkg::ST_NORM : apphd_pkg::ST_DRAIN;
      end
      apphd_pkg::ST_NORM: begin
        if (term_q == 2'd2 && vec_q == 2'd3) state_d = apphd_pkg::ST_DOT;
      end
      apphd_pkg::ST_DOT: begin
        if (term_q == 2'd2 && vec_q == 2'd3) state_d = apphd_pkg::ST_QUAD;
      end
      apphd_pkg::ST_QUAD: begin
        if (term_q == 2'd3) state_d = apphd_pkg::ST_LSQ;
      end
      apphd_pkg::ST_LSQ: begin
        if (term_q == 2'd3) state_d = apphd_pkg::ST_RLIM;
      end
      apphd_pkg::ST_RLIM: begin
        if (term_q == 2'd3) begin
          state_d = (vec_q == 2'd3) ? apphd_pkg::ST_DRAIN : apphd_pkg::ST_QUAD;
        end
      end
      apphd_pkg::ST_DRAIN: begin
        state_d = apphd_pkg::ST_FINISH;
      end
      apphd_pkg::ST_FINISH: begin
        if (sts_i.out_free) state_d = apphd_pkg::ST_IDLE;
      end
      default: state_d = apphd_pkg::ST_IDLE;
    endcase
  end

  // Advance vector and term counters
  always_comb begin
    vec_d  = vec_q;
    term_d = term_q;
    unique case (state_q)
      apphd_pkg::ST_IDLE: begin
        vec_d  = '0;
        term_d = '0;
      end
      apphd_pkg::ST_NORM, apphd_pkg::ST_DOT: begin
        if (term_q == 2'd2) begin
          term_d = '0;
          vec_d  = vec_q + 2'd1;
        end else begin
          term_d = term_q + 2'd1;
        end
      end
      apphd_pkg::ST_QUAD, apphd_pkg::ST_LSQ: begin
        term_d = term_q + 2'd1;
      end
      apphd_pkg::ST_RLIM: begin
        term_d = term_q + 2'd1;
        if (term_q == 2'd3) vec_d = vec_q + 2'd1;
      end
      default: ;
    endcase
  end

  // Drive commands
  always_comb begin
    cmd_o      = '0;
    cmd_o.vec  = vec_q;
    cmd_o.term = term_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      apphd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      apphd_pkg::ST_LIM2: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = apphd_pkg::OP_LIM2;
      end
      apphd_pkg::ST_NORM: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = apphd_pkg::OP_NORM;
      end
      apphd_pkg::ST_DOT: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = apphd_pkg::OP_DOT;
      end
      apphd_pkg::ST_QUAD: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = apphd_pkg::OP_QUAD;
      end
      apphd_pkg::ST_LSQ: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = apphd_pkg::OP_LSQ;
      end
      apphd_pkg::ST_RLIM: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = apphd_pkg::OP_RLIM;
      end
      apphd_pkg::ST_FINISH: begin
        cmd_o.finish = sts_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/apphd_dpath.sv =====
// ----------------------------------------------------------------------------
// apphd_dpath: datapath of the pose detector
// Joint differences, one shared signed multiplier with a shifting
// accumulator, the per-test results, the hold counter and the result register.
// ----------------------------------------------------------------------------
module apphd_dpath #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  apphd_pkg::cmd_t               cmd_i,
  output apphd_pkg::sts_t               sts_o,
  input  logic [apphd_pkg::LIM_W-1:0]   cos_limit_i,
  input  logic [apphd_pkg::HOLD_W-1:0]  hold_frames_i,
  input  logic                          tracking_i,
  input  logic                          joints_valid_i,
  input  logic [apphd_pkg::JOINT_W-1:0] left_shoulder_i,
  input  logic [apphd_pkg::JOINT_W-1:0] left_hand_i,
  input  logic [apphd_pkg::JOINT_W-1:0] right_shoulder_i,
  input  logic [apphd_pkg::JOINT_W-1:0] right_hand_i,
  input  logic [apphd_pkg::JOINT_W-1:0] neck_i,
  input  logic [apphd_pkg::JOINT_W-1:0] head_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          pose_now_o,
  output logic                          pose_found_o,
  output logic                          pose_lost_o,
  output logic                          posing_o
);

  // Difference width, chunk width, multiplier and accumulator widths
  localparam int unsigned D      = COORD_BITS + 1;
  localparam int unsigned LIM2_W = 2 * apphd_pkg::LIM_W;
  localparam int unsigned H      = (D > LIM2_W) ? D : LIM2_W;
  localparam int unsigned MW     = H + 1;
  localparam int unsigned PW     = 2 * H + 2;
  localparam int unsigned NW     = 2 * H;
  localparam int unsigned QW     = 4 * H;
  localparam int unsigned ACC_W  = 4 * H + 21;
  localparam int unsigned EXT_W  = (3 * COORD_BITS > apphd_pkg::JOINT_W) ?
                                   3 * COORD_BITS : apphd_pkg::JOINT_W;
  localparam int unsigned CNT_MAX = (1 << apphd_pkg::CNT_W) - 1;

  typedef logic [2:0][D-1:0] vec_t;

  typedef enum logic [2:0] {
    DST_NONE,
    DST_LIM2,
    DST_NORM,
    DST_DOT,
    DST_QUAD,
    DST_PASS
  } dst_e;

  typedef struct packed {
    logic       en;
    logic       clr;
    logic       neg;
    logic       sh16;
    logic [1:0] shc;
    dst_e       dst;
    logic [1:0] vec;
  } acc_ctl_t;

  // Vector from one joint to another, coordinates unpacked and sign extended
  function automatic vec_t diff_of(input logic [apphd_pkg::JOINT_W-1:0] src_j,
                                   input logic [apphd_pkg::JOINT_W-1:0] dst_j);
    logic [EXT_W-1:0]    se;
    logic [EXT_W-1:0]    de;
    logic signed [D-1:0] sc;
    logic signed [D-1:0] dc;
    vec_t                r;
    se = EXT_W'(src_j);
    de = EXT_W'(dst_j);
    for (int i = 0; i < 3; i++) begin
      sc   = D'($signed(se[i*COORD_BITS +: COORD_BITS]));
      dc   = D'($signed(de[i*COORD_BITS +: COORD_BITS]));
      r[i] = dc - sc;
    end
    return r;
  endfunction

  // Vectors: 0 shoulder axis, 1 head axis, 2 left arm, 3 right arm
  vec_t                     diff_q [4];
  logic                     trk_q;
  logic                     vld_q;
  logic [H-1:0]             lim2_q;
  logic [1:0][H-1:0]        nrm_q [4];
  logic [1:0][H-1:0]        dot_q [4];
  logic [3:0][H-1:0]        quad_q;
  logic [3:0]               pass_q;
  logic signed [PW-1:0]     prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  acc_ctl_t                 ctl_q;
  acc_ctl_t                 ctl_d;
  logic signed [MW-1:0]     opa;
  logic signed [MW-1:0]     opb;
  vec_t                     vsel;
  vec_t                     vaxis;
  vec_t                     varm;
  logic [1:0][H-1:0]        naxis;
  logic [1:0][H-1:0]        narm;
  logic [1:0][H-1:0]        dsel;
  logic                     lsq_a_hi;
  logic                     lsq_b_hi;
  logic signed [ACC_W-1:0]  ext;
  logic signed [ACC_W-1:0]  shd;
  logic signed [ACC_W-1:0]  shd16;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [ACC_W-1:0]  acc_abs;
  logic                     held_q, held_d;
  logic [apphd_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                     now_c;
  logic                     found_c;
  logic                     lost_c;
  logic                     out_valid_q;
  logic                     pose_now_q;
  logic                     pose_found_q;
  logic                     pose_lost_q;
  logic                     posing_q;

  // Capture the frame as four difference vectors
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      diff_q[0] <= diff_of(left_shoulder_i, right_shoulder_i);
      diff_q[1] <= diff_of(neck_i, head_i);
      diff_q[2] <= diff_of(left_shoulder_i, left_hand_i);
      diff_q[3] <= diff_of(right_shoulder_i, right_hand_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_q <= 1'b0;
      vld_q <= 1'b0;
    end else if (cmd_i.load) begin
      trk_q <= tracking_i;
      vld_q <= joints_valid_i;
    end
  end

  // Operand selection: test t pairs axis t[1] with arm t[0]
  always_comb begin
    vsel     = diff_q[cmd_i.vec];
    vaxis    = cmd_i.vec[1] ? diff_q[1] : diff_q[0];
    varm     = cmd_i.vec[0] ? diff_q[2] : diff_q[3];
    naxis    = cmd_i.vec[1] ? nrm_q[1] : nrm_q[0];
    narm     = cmd_i.vec[0] ? nrm_q[2] : nrm_q[3];
    dsel     = dot_q[cmd_i.vec];
    lsq_a_hi = (cmd_i.term == 2'd3);
    lsq_b_hi = (cmd_i.term != 2'd0);
    opa      = '0;
    opb      = '0;
    ctl_d    = '0;
    ctl_d.en  = cmd_i.issue;
    ctl_d.vec = cmd_i.vec;
    unique case (cmd_i.op)
      apphd_pkg::OP_LIM2: begin
        opa       = MW'(cos_limit_i);
        opb       = MW'(cos_limit_i);
        ctl_d.clr = 1'b1;
        ctl_d.dst = DST_LIM2;
      end
      apphd_pkg::OP_NORM: begin
        opa       = MW'($signed(vsel[cmd_i.term]));
        opb       = MW'($signed(vsel[cmd_i.term]));
        ctl_d.clr = (cmd_i.term == 2'd0);
        ctl_d.dst = (cmd_i.term == 2'd2) ? DST_NORM : DST_NONE;
      end
      apphd_pkg::OP_DOT: begin
        opa       = MW'($signed(vaxis[cmd_i.term]));
        opb       = MW'($signed(varm[cmd_i.term]));
        ctl_d.clr = (cmd_i.term == 2'd0);
        ctl_d.dst = (cmd_i.term == 2'd2) ? DST_DOT : DST_NONE;
      end
      apphd_pkg::OP_QUAD: begin
        opa       = MW'(naxis[cmd_i.term[1]]);
        opb       = MW'(narm[cmd_i.term[0]]);
        ctl_d.clr = (cmd_i.term == 2'd0);
        ctl_d.shc = {1'b0, cmd_i.term[1]} + {1'b0, cmd_i.term[0]};
        ctl_d.dst = (cmd_i.term == 2'd3) ? DST_QUAD : DST_NONE;
      end
      apphd_pkg::OP_LSQ: begin
        // cross term taken twice
        opa        = MW'(dsel[lsq_a_hi]);
        opb        = MW'(dsel[lsq_b_hi]);
        ctl_d.clr  = (cmd_i.term == 2'd0);
        ctl_d.neg  = 1'b1;
        ctl_d.sh16 = 1'b1;
        ctl_d.shc  = {1'b0, lsq_a_hi} + {1'b0, lsq_b_hi};
      end
      apphd_pkg::OP_RLIM: begin
        opa       = MW'(quad_q[cmd_i.term]);
        opb       = MW'(lim2_q);
        ctl_d.shc = cmd_i.term;
        ctl_d.dst = (cmd_i.term == 2'd3) ? DST_PASS : DST_NONE;
      end
      default: ;
    endcase
  end

  // Multiply stage
  always_ff @(posedge clk_i) begin
    prod_q <= opa * opb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  // Align the product by whole chunks, then negate or add
  always_comb begin
    ext = ACC_W'(prod_q);
    unique case (ctl_q.shc)
      2'd0: shd = ext;
      2'd1: shd = ext <<< H;
      2'd2: shd = ext <<< (2 * H);
      2'd3: shd = ext <<< (3 * H);
      default: shd = ext;
    endcase
    shd16   = ctl_q.sh16 ? (shd <<< 16) : shd;
    addend  = ctl_q.neg ? -shd16 : shd16;
    acc_d   = ctl_q.clr ? addend : acc_q + addend;
    acc_abs = acc_d[ACC_W-1] ? -acc_d : acc_d;
  end

  // Accumulate and write finished sums to their destination
  always_ff @(posedge clk_i) begin
    if (ctl_q.en) begin
      acc_q <= acc_d;
      unique case (ctl_q.dst)
        DST_NONE: ;
        DST_LIM2: lim2_q <= acc_d[H-1:0];
        DST_NORM: nrm_q[ctl_q.vec] <= acc_d[NW-1:0];
        DST_DOT:  dot_q[ctl_q.vec] <= acc_abs[NW-1:0];
        DST_QUAD: quad_q <= acc_d[QW-1:0];
        DST_PASS: pass_q[ctl_q.vec] <= !acc_d[ACC_W-1] && (acc_d != '0);
        default: ;
      endcase
    end
  end

  // Hold counter and pose flag update
  always_comb begin
    now_c   = trk_q & vld_q & (&pass_q);
    held_d  = held_q;
    cnt_d   = cnt_q;
    found_c = 1'b0;
    lost_c  = 1'b0;
    if (trk_q) begin
      if (now_c) begin
        if (cnt_q != apphd_pkg::CNT_W'(CNT_MAX)) cnt_d = cnt_q + 1'b1;
        if (cnt_d > hold_frames_i && !held_q) begin
          held_d  = 1'b1;
          found_c = 1'b1;
        end
      end else if (held_q) begin
        cnt_d  = '0;
        held_d = 1'b0;
        lost_c = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        held_q <= held_d;
        cnt_q  <= cnt_d;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      pose_now_q   <= now_c;
      pose_found_q <= found_c;
      pose_lost_q  <= lost_c;
      posing_q     <= held_d;
    end
  end

  assign sts_o.run      = trk_q & vld_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign pose_now_o     = pose_now_q;
  assign pose_found_o   = pose_found_q;
  assign pose_lost_o    = pose_lost_q;
  assign posing_o       = posing_q;

endmodule

// ===== rtl/arm_pose_hold_detector_unit.sv =====
// ----------------------------------------------------------------------------
// arm_pose_hold_detector_unit: arm pose hold detector, top level
// Checks each skeleton frame for both arms held perpendicular to the
// shoulder and head axes and tracks how long the pose is held.
// ----------------------------------------------------------------------------
// One frame is one transaction on in_i and gives one result transaction on
// out_o. A frame is accepted only after the previous one has been worked
// through; an untracked frame or one with invalid joints gets only the
// limit squaring. A tracked frame with valid joints is worked by the single
// shared signed multiplier of (max(COORD_BITS+1, 18)+1) bits, which runs 73
// operations per frame: the limit squared, four squared lengths, four dot
// products and, for each of the four tests, the exact product
// |a|^2*|b|^2*limit^2 against dot^2*2^16 in chunks. A finished result waits
// in its output register, so the next frame is accepted while it is still
// held. cos_limit lies at byte address 0 and hold_frames at 4; write them
// only while the block is idle.
module arm_pose_hold_detector_unit #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  apphd_in_if.sink                     in_i,
  apphd_out_if.source                  out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [apphd_pkg::APB_AW-1:0] paddr,
  input  logic [apphd_pkg::APB_DW-1:0] pwdata,
  output logic [apphd_pkg::APB_DW-1:0] prdata,
  output logic                         pready
);

  logic [apphd_pkg::LIM_W-1:0]  cos_limit_q;
  logic [apphd_pkg::HOLD_W-1:0] hold_frames_q;
  logic                         cfg_wr;
  apphd_pkg::cmd_t              cmd;
  apphd_pkg::sts_t              sts;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_limit_q   <= apphd_pkg::COS_LIMIT_RST;
      hold_frames_q <= apphd_pkg::HOLD_FRAMES_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        apphd_pkg::REG_COS_LIMIT:   cos_limit_q   <= pwdata[apphd_pkg::LIM_W-1:0];
        apphd_pkg::REG_HOLD_FRAMES: hold_frames_q <= pwdata[apphd_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[2])
      apphd_pkg::REG_COS_LIMIT:   prdata = apphd_pkg::APB_DW'(cos_limit_q);
      apphd_pkg::REG_HOLD_FRAMES: prdata = apphd_pkg::APB_DW'(hold_frames_q);
      default:                    prdata = '0;
    endcase
  end

  // Sequencer
  apphd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Arithmetic, hold tracking and result register
  apphd_dpath #(
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cos_limit_i      (cos_limit_q),
    .hold_frames_i    (hold_frames_q),
    .tracking_i       (in_i.tracking),
    .joints_valid_i   (in_i.joints_valid),
    .left_shoulder_i  (in_i.left_shoulder),
    .left_hand_i      (in_i.left_hand),
    .right_shoulder_i (in_i.right_shoulder),
    .right_hand_i     (in_i.right_hand),
    .neck_i           (in_i.neck),
    .head_i           (in_i.head),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .pose_now_o       (out_o.pose_now),
    .pose_found_o     (out_o.pose_found),
    .pose_lost_o      (out_o.pose_lost),
    .posing_o         (out_o.posing)
  );

endmodule
